>>> sv/chm_pkg.sv
// package: types, constants and state codes for the chained hash map
package chm_pkg;

  localparam int MAX_BUCKETS  = 256;
  localparam int POOL_ENTRIES = 1024;
  localparam int BKT_W = $clog2(MAX_BUCKETS);
  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int PTR_W = IDX_W + 1;
  localparam int CNT_W = BKT_W + 1;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_LOOKUP = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_ITER_RESET = 3'd3;
  localparam logic [2:0] CMD_ITER_NEXT = 3'd4;

  localparam logic [2:0] ST_SUCCESS = 3'd0;
  localparam logic [2:0] ST_EXISTS = 3'd1;
  localparam logic [2:0] ST_NOT_EXISTS = 3'd2;
  localparam logic [2:0] ST_NO_MORE = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] key;
    logic [63:0] value;
  } chm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_key;
    logic [63:0] found_value;
  } chm_out_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] rem;
  } chm_mod_stat_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MOD, S_HEAD, S_WALK, S_CMP, S_A1, S_A2,
    S_R1, S_R2, S_ITRD, S_SEEK, S_SEEKRD, S_DONE
  } chm_state_t;

endpackage

>>> sv/chm_mod.sv
// remainder unit: key modulo bucket count, one quotient bit per cycle
module chm_mod
  import chm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        dividend,
  input  logic [CNT_W-1:0]   divisor,
  output chm_mod_stat_t      stat
);

  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [31:0]      q_r, q_nxt;
  logic [CNT_W:0]   trial;

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    trial = {rem_r, q_r[31]};
    stat.done = 1'b0;
    stat.rem = rem_r[BKT_W-1:0];
    if (start) begin
      cnt_nxt = 6'd0;
      busy_nxt = 1'b1;
      rem_nxt = '0;
      q_nxt = dividend;
    end else if (busy_r) begin
      // remainder stays below divisor, so one subtract per step
      if (trial >= {1'b0, divisor}) trial = trial - {1'b0, divisor};
      rem_nxt = trial[CNT_W-1:0];
      q_nxt = {q_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
    if (busy_r == 1'b0 && cnt_r == 6'd32) stat.done = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= (stat.done && !start) ? 6'd33 : cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
  end

endmodule

>>> sv/chained_hash_map.sv
// top level: chained hash map with sequencer, memories and remainder unit
//
//  channel   ports                           direction
//  input     in_valid, in_stall, in_data     item in, stall out
//  result    out_valid, out_stall, out_data  item out, stall in
//  config    cfg_we, cfg_wdata               bucket count write
//
// add, lookup, remove: the bucket remainder (one bit per cycle in the
// shared remainder unit), then the head read, a walk and compare per
// chain entry visited, a final walk step on a miss, the link (S_A1, S_A2)
// or unlink (S_R1, S_R2) states, and the hand-over to the output register
// iterator reset and next: a head read (S_SEEK, S_SEEKRD) per bucket
// scanned, paced by the single head memory read port
// after reset a clearing pass over all 1024 pool entries rebuilds the free list;
// no item is taken meanwhile. one item at a time; a result waits in the output register
module chained_hash_map
  import chm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  chm_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output chm_out_t    out_data,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  chm_state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] val_r, val_nxt;
  logic [BKT_W-1:0] b_r, b_nxt;
  logic [PTR_W-1:0] head_r, head_nxt, cur_r, cur_nxt, nx_r, nx_nxt, pv_r, pv_nxt;
  logic [PTR_W-1:0] free_head_r, free_head_nxt, iter_entry_r, iter_entry_nxt;
  logic [BKT_W-1:0] iter_bucket_r, iter_bucket_nxt;
  logic [CNT_W-1:0] seek_r, seek_nxt, bc_r, n_eff;
  chm_out_t res_r, res_nxt, out_data_r;
  logic out_valid_r;
  logic mod_start;
  chm_mod_stat_t mod_stat;

  logic [PTR_W-1:0] head_mem [MAX_BUCKETS];
  logic [31:0]      key_mem [POOL_ENTRIES];
  logic [63:0]      val_mem [POOL_ENTRIES];
  logic [PTR_W-1:0] nxt_mem [POOL_ENTRIES];
  logic [PTR_W-1:0] prv_mem [POOL_ENTRIES];

  logic [PTR_W-1:0] head_rd_r, nxt_rd_r, prv_rd_r;
  logic [31:0] key_rd_r;
  logic [63:0] val_rd_r;

  logic head_we, kv_we, nxt_we, prv_we;
  logic [BKT_W-1:0] head_wa, head_ra;
  logic [IDX_W-1:0] kv_wa, nxt_wa, prv_wa, ent_ra;
  logic [PTR_W-1:0] head_wd, nxt_wd, prv_wd, new_head;

  logic in_acc, out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    if (bc_r == '0) n_eff = CNT_W'(1);
    else if (bc_r > CNT_W'(MAX_BUCKETS)) n_eff = CNT_W'(MAX_BUCKETS);
    else n_eff = bc_r;
  end

  // the unit latches its dividend on start, which is the accept cycle
  chm_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(in_data.key),
    .divisor(n_eff), .stat(mod_stat)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd_nxt = cmd_r;
    key_nxt = key_r;
    val_nxt = val_r;
    b_nxt = b_r;
    head_nxt = head_r;
    cur_nxt = cur_r;
    nx_nxt = nx_r;
    pv_nxt = pv_r;
    free_head_nxt = free_head_r;
    iter_entry_nxt = iter_entry_r;
    iter_bucket_nxt = iter_bucket_r;
    seek_nxt = seek_r;
    res_nxt = res_r;
    mod_start = 1'b0;
    head_we = 1'b0; head_wa = b_r; head_wd = NIL; head_ra = b_r;
    kv_we = 1'b0; kv_wa = free_head_r[IDX_W-1:0];
    nxt_we = 1'b0; nxt_wa = cur_r[IDX_W-1:0]; nxt_wd = NIL;
    prv_we = 1'b0; prv_wa = cur_r[IDX_W-1:0]; prv_wd = NIL;
    ent_ra = cur_r[IDX_W-1:0];
    new_head = (head_r == cur_r || pv_r[IDX_W]) ? nx_r : head_r;
    case (state_r)
      S_INIT: begin
        nxt_we = 1'b1; nxt_wa = cnt_r; nxt_wd = PTR_W'(cnt_r) + PTR_W'(1);
        prv_we = 1'b1; prv_wa = cnt_r; prv_wd = NIL;
        if (cnt_r < IDX_W'(MAX_BUCKETS)) begin
          head_we = 1'b1; head_wa = cnt_r[BKT_W-1:0]; head_wd = NIL;
        end
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(POOL_ENTRIES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        ent_ra = iter_entry_r[IDX_W-1:0];
        if (in_acc) begin
          cmd_nxt = in_data.command;
          key_nxt = in_data.key;
          val_nxt = in_data.value;
          res_nxt = '0;
          case (in_data.command)
            CMD_ADD, CMD_LOOKUP, CMD_REMOVE: state_nxt = S_MOD;
            CMD_ITER_RESET: begin
              iter_bucket_nxt = '0;
              iter_entry_nxt = NIL;
              seek_nxt = '0;
              state_nxt = S_SEEK;
            end
            CMD_ITER_NEXT: begin
              if (iter_entry_r[IDX_W]) begin
                res_nxt.status = ST_NO_MORE;
                state_nxt = S_DONE;
              end else state_nxt = S_ITRD;
            end
            default: begin
              res_nxt.status = ST_NOT_EXISTS;
              state_nxt = S_DONE;
            end
          endcase
          if (in_data.command == CMD_ADD || in_data.command == CMD_LOOKUP ||
              in_data.command == CMD_REMOVE) mod_start = 1'b1;
        end
      end
      S_MOD: begin
        head_ra = mod_stat.rem;
        if (mod_stat.done) begin
          b_nxt = mod_stat.rem;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        head_nxt = head_rd_r;
        cur_nxt = head_rd_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        ent_ra = cur_r[IDX_W-1:0];
        if (cur_r[IDX_W]) begin
          // key not in chain
          if (cmd_r == CMD_ADD) begin
            if (free_head_r[IDX_W]) begin
              res_nxt.status = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              ent_ra = free_head_r[IDX_W-1:0];
              state_nxt = S_A1;
            end
          end else begin
            res_nxt.status = ST_NOT_EXISTS;
            state_nxt = S_DONE;
          end
        end else state_nxt = S_CMP;
      end
      S_CMP: begin
        if (key_rd_r == key_r) begin
          case (cmd_r)
            CMD_ADD: begin
              res_nxt.status = ST_EXISTS;
              state_nxt = S_DONE;
            end
            CMD_LOOKUP: begin
              res_nxt.found_value = val_rd_r;
              state_nxt = S_DONE;
            end
            default: begin
              res_nxt.found_value = val_rd_r;
              nx_nxt = nxt_rd_r;
              pv_nxt = prv_rd_r;
              state_nxt = S_R1;
            end
          endcase
        end else begin
          cur_nxt = nxt_rd_r;
          state_nxt = S_WALK;
        end
      end
      S_A1: begin
        free_head_nxt = nxt_rd_r;
        kv_we = 1'b1; kv_wa = free_head_r[IDX_W-1:0];
        nxt_we = 1'b1; nxt_wa = free_head_r[IDX_W-1:0]; nxt_wd = head_r;
        prv_we = 1'b1; prv_wa = free_head_r[IDX_W-1:0]; prv_wd = NIL;
        cur_nxt = free_head_r;
        state_nxt = S_A2;
      end
      S_A2: begin
        if (!head_r[IDX_W]) begin
          prv_we = 1'b1; prv_wa = head_r[IDX_W-1:0]; prv_wd = cur_r;
        end
        head_we = 1'b1; head_wa = b_r; head_wd = cur_r;
        state_nxt = S_DONE;
      end
      S_R1: begin
        // unlink: head or predecessor skips the entry
        if (head_r == cur_r || pv_r[IDX_W]) begin
          head_we = 1'b1; head_wa = b_r; head_wd = nx_r;
        end else begin
          nxt_we = 1'b1; nxt_wa = pv_r[IDX_W-1:0]; nxt_wd = nx_r;
        end
        if (!nx_r[IDX_W]) begin
          prv_we = 1'b1; prv_wa = nx_r[IDX_W-1:0];
          prv_wd = (new_head == nx_r) ? NIL : pv_r;
        end
        state_nxt = S_R2;
      end
      S_R2: begin
        nxt_we = 1'b1; nxt_wa = cur_r[IDX_W-1:0]; nxt_wd = free_head_r;
        prv_we = 1'b1; prv_wa = cur_r[IDX_W-1:0]; prv_wd = NIL;
        free_head_nxt = cur_r;
        state_nxt = S_DONE;
      end
      S_ITRD: begin
        res_nxt.found_key = key_rd_r;
        res_nxt.found_value = val_rd_r;
        if (!nxt_rd_r[IDX_W]) begin
          iter_entry_nxt = nxt_rd_r;
          state_nxt = S_DONE;
        end else begin
          iter_entry_nxt = NIL;
          seek_nxt = CNT_W'(iter_bucket_r) + CNT_W'(1);
          state_nxt = S_SEEK;
        end
      end
      S_SEEK: begin
        head_ra = seek_r[BKT_W-1:0];
        if (seek_r >= n_eff) state_nxt = S_DONE;
        else state_nxt = S_SEEKRD;
      end
      S_SEEKRD: begin
        if (!head_rd_r[IDX_W]) begin
          iter_entry_nxt = head_rd_r;
          iter_bucket_nxt = seek_r[BKT_W-1:0];
          state_nxt = S_DONE;
        end else begin
          seek_nxt = seek_r + CNT_W'(1);
          state_nxt = S_SEEK;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r <= '0;
      free_head_r <= '0;
      iter_entry_r <= NIL;
      iter_bucket_r <= '0;
      bc_r <= CNT_W'(MAX_BUCKETS);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      free_head_r <= free_head_nxt;
      iter_entry_r <= iter_entry_nxt;
      iter_bucket_r <= iter_bucket_nxt;
      if (cfg_we) bc_r <= cfg_wdata;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (state_r == S_DONE && out_free) out_data_r <= res_r;
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    b_r <= b_nxt;
    head_r <= head_nxt;
    cur_r <= cur_nxt;
    nx_r <= nx_nxt;
    pv_r <= pv_nxt;
    seek_r <= seek_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[kv_wa] <= key_r;
      val_mem[kv_wa] <= val_r;
    end
    key_rd_r <= key_mem[ent_ra];
    val_rd_r <= val_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_r <= nxt_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd_r <= prv_mem[ent_ra];
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= NIL)
    else $error("free list head out of range");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && mod_stat.done) |=> state_r == S_HEAD)
    else $error("remainder finished but bucket head not read");

endmodule

>>> sim/tb_chained_hash_map.sv
// testbench for the chained hash map: scoreboard with a map predictor, random traffic
`timescale 1ns / 1ps

module tb_chained_hash_map;
  import chm_pkg::*;

  // map predictor plus queue of expected results
  class map_scoreboard;
    int unsigned nbuckets;
    int unsigned head[MAX_BUCKETS];
    bit [31:0]   ekey[POOL_ENTRIES];
    bit [63:0]   eval[POOL_ENTRIES];
    int unsigned enext[POOL_ENTRIES];
    int unsigned eprev[POOL_ENTRIES];
    int unsigned free_ptr, it_bucket, it_entry;
    chm_out_t    pending[$];
    int          errors;
    int          live;

    function new();
      nbuckets = 256;
      for (int i = 0; i < MAX_BUCKETS; i++) head[i] = POOL_ENTRIES;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        ekey[i] = 0; eval[i] = 0; enext[i] = i + 1; eprev[i] = POOL_ENTRIES;
      end
      free_ptr = 0; it_bucket = 0; it_entry = POOL_ENTRIES;
      errors = 0; live = 0;
    endfunction

    function int unsigned eff();
      if (nbuckets == 0) return 1;
      if (nbuckets > MAX_BUCKETS) return MAX_BUCKETS;
      return nbuckets;
    endfunction

    function int unsigned find(int unsigned b, bit [31:0] k);
      int unsigned e;
      int unsigned steps;
      e = head[b];
      steps = 0;
      while (e < POOL_ENTRIES && steps < POOL_ENTRIES) begin
        if (ekey[e] == k) return e;
        e = enext[e];
        steps++;
      end
      return POOL_ENTRIES;
    endfunction

    function void seek(int unsigned start);
      it_entry = POOL_ENTRIES;
      for (int unsigned i = start; i < eff(); i++)
        if (head[i] < POOL_ENTRIES) begin
          it_entry = head[i];
          it_bucket = i;
          return;
        end
    endfunction

    function void note_item(chm_in_t it);
      chm_out_t r;
      int unsigned b, e, nx, pv;
      r = '0;
      r.status = ST_SUCCESS;
      b = it.key % eff();
      case (it.command)
        CMD_ADD: begin
          if (find(b, it.key) < POOL_ENTRIES) r.status = ST_EXISTS;
          else if (free_ptr >= POOL_ENTRIES) r.status = ST_FULL;
          else begin
            e = free_ptr;
            free_ptr = enext[e];
            ekey[e] = it.key; eval[e] = it.value;
            enext[e] = head[b]; eprev[e] = POOL_ENTRIES;
            if (head[b] < POOL_ENTRIES) eprev[head[b]] = e;
            head[b] = e;
            live++;
          end
        end
        CMD_LOOKUP, CMD_REMOVE: begin
          e = find(b, it.key);
          if (e >= POOL_ENTRIES) r.status = ST_NOT_EXISTS;
          else begin
            r.found_value = eval[e];
            if (it.command == CMD_REMOVE) begin
              nx = enext[e]; pv = eprev[e];
              if (head[b] == e || pv >= POOL_ENTRIES) head[b] = nx;
              else enext[pv] = nx;
              if (nx < POOL_ENTRIES) eprev[nx] = (head[b] == nx) ? POOL_ENTRIES : pv;
              eprev[e] = POOL_ENTRIES;
              enext[e] = free_ptr;
              free_ptr = e;
              live--;
            end
          end
        end
        CMD_ITER_RESET: begin
          it_bucket = 0;
          seek(0);
        end
        CMD_ITER_NEXT: begin
          if (it_entry >= POOL_ENTRIES) r.status = ST_NO_MORE;
          else begin
            r.found_key = ekey[it_entry];
            r.found_value = eval[it_entry];
            if (enext[it_entry] < POOL_ENTRIES) it_entry = enext[it_entry];
            else seek(it_bucket + 1);
          end
        end
        default: r.status = ST_NOT_EXISTS;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(chm_out_t got);
      chm_out_t x;
      if (pending.size() == 0) begin
        $error("unexpected result item status=%0d", got.status);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.status !== x.status) begin
        $error("status expected %0d actual %0d", x.status, got.status); errors++;
      end
      if (got.found_key !== x.found_key) begin
        $error("found_key expected %h actual %h", x.found_key, got.found_key); errors++;
      end
      if (got.found_value !== x.found_value) begin
        $error("found_value expected %h actual %h", x.found_value, got.found_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0, cfg_we = 0;
  logic [8:0] cfg_wdata = '0;
  chm_in_t in_data = '0;
  logic in_stall, out_valid;
  chm_out_t out_data;

  map_scoreboard sb = new();
  int send_idle = 0, recv_stall = 0;
  int hold_off = 0;
  longint cycles = 0;
  bit [31:0] used_keys[$];

  always #4 clk = ~clk;

  chained_hash_map uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_wdata
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: sample at rising edge, drive stall at falling edge
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(99) < recv_stall);
  end

  // valid stays high into the next item unless the sender idles
  task automatic send(chm_in_t it);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic cmd(logic [2:0] c, bit [31:0] k, bit [63:0] v);
    chm_in_t it;
    it.command = c; it.key = k; it.value = v;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_buckets(logic [8:0] n);
    drain();
    cfg_we <= 1; cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 0;
    sb.nbuckets = n;
  endtask

  function automatic bit [31:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(99) < 60)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    return (($urandom_range(3) == 0) ? $urandom() : $urandom_range(600));
  endfunction

  task automatic random_phase(int n, int si, int rs);
    bit [31:0] k;
    int r;
    send_idle = si; recv_stall = rs;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = pick_key();
      if (r < 40) begin
        cmd(CMD_ADD, k, {$urandom(), $urandom()});
        used_keys.push_back(k);
        if (used_keys.size() > 200) void'(used_keys.pop_front());
      end else if (r < 60) cmd(CMD_LOOKUP, k, {$urandom(), $urandom()});
      else if (r < 82) cmd(CMD_REMOVE, k, {$urandom(), $urandom()});
      else if (r < 96) begin
        // short walk of the table, no changes while walking
        cmd(CMD_ITER_RESET, $urandom(), {$urandom(), $urandom()});
        for (int j = 0; j <= sb.live && j < 4; j++)
          cmd(CMD_ITER_NEXT, $urandom(), {$urandom(), $urandom()});
      end else cmd(3'($urandom_range(7, 5)), $urandom(), {$urandom(), $urandom()});
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1;
    // directed: extremes, every command, duplicate, missing, unknown
    cmd(CMD_ITER_NEXT, 0, 0);
    cmd(CMD_ADD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    cmd(CMD_ADD, 0, 0);
    cmd(CMD_ADD, 256, 64'h1234);
    cmd(CMD_ADD, 256, 64'h5678);
    cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 0);
    cmd(CMD_LOOKUP, 7, 0);
    cmd(CMD_ITER_RESET, 0, 0);
    repeat (5) cmd(CMD_ITER_NEXT, 0, 0);
    cmd(CMD_REMOVE, 0, 0);
    cmd(CMD_REMOVE, 0, 0);
    cmd(CMD_ITER_RESET, 0, 0);
    cmd(CMD_REMOVE, 256, 0);
    cmd(CMD_ITER_NEXT, 0, 0);
    cmd(3'd5, 1, 1); cmd(3'd7, 32'hAAAA_5555, 64'h5555_AAAA_5555_AAAA);
    // bucket count extremes and out of range
    set_buckets(0);
    cmd(CMD_ADD, 33, 64'hAB);
    cmd(CMD_LOOKUP, 33, 0);
    set_buckets(9'h1FF);
    cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 0);
    set_buckets(1);
    cmd(CMD_ITER_RESET, 0, 0);
    repeat (4) cmd(CMD_ITER_NEXT, 0, 0);

    set_buckets(16);
    random_phase(40, 0, 0);
    // long receiver hold-off while items keep coming
    hold_off = 400;
    random_phase(15, 0, 0);
    set_buckets(256);
    random_phase(30, 65, 0);
    set_buckets(7);
    random_phase(30, 0, 65);
    set_buckets(1);
    random_phase(20, 20, 20);
    // fill the pool to reach full status
    set_buckets(256);
    send_idle = 0; recv_stall = 0;
    for (int i = 0; sb.free_ptr < POOL_ENTRIES && i < 1100; i++)
      cmd(CMD_ADD, 32'h1000 + i, {$urandom(), $urandom()});
    cmd(CMD_ADD, 32'h9000, 64'h1);
    cmd(CMD_REMOVE, 32'h1005, 0);
    cmd(CMD_ADD, 32'h9999, 64'h77);
    random_phase(35, 20, 20);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> sim.f
sv/chm_pkg.sv
sv/chm_mod.sv
sv/chained_hash_map.sv
sim/tb_chained_hash_map.sv
